[hdl/afps_pkg.sv]
// Shared types and constants for the converter frame parse and scale block.
package afps_pkg;

	localparam int CHANNELS = 2;

	localparam int CODE_W  = 24;
	localparam int VALUE_W = 32;
	localparam int VREF_W  = 31;
	localparam int GAIN_W  = 3;
	localparam int STATUS_W = 16;
	localparam int PROD_W  = CODE_W + VREF_W;
	// 2^23 - 1 and 2^23 full-scale code magnitudes
	localparam int FS_SHIFT = CODE_W - 1;
	localparam logic [CODE_W-1:0] POS_FULL_SCALE = CODE_W'((1 << FS_SHIFT) - 1);

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_VREF        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_FIRST  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_SECOND = 2'd2;

	localparam logic [VREF_W-1:0] VREF_RESET = 31'd1200000000;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd0;

	typedef struct packed {
		logic [STATUS_W-1:0]       status_word;
		logic [CODE_W-1:0]         code_first;
		logic [CODE_W-1:0]         code_second;
		logic signed [VALUE_W-1:0] prior_first;
		logic signed [VALUE_W-1:0] prior_second;
		logic                      want_nanovolts;
	} frame_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_first;
		logic signed [VALUE_W-1:0] value_second;
		logic [1:0]                ready_mask;
	} result_t;

	// per-stage load strobes shared by all lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

[hdl/afps_lane.sv]
// One channel lane: sign extension, full-scale multiply and constant divide.
module afps_lane (
	input  logic                                  clk,
	input  afps_pkg::adv_t                        adv,
	input  logic [afps_pkg::CODE_W-1:0]           code,
	input  logic signed [afps_pkg::VALUE_W-1:0]   prior,
	input  logic                                  rdy,
	input  logic                                  nano,
	input  logic [afps_pkg::GAIN_W-1:0]           gain,
	input  logic [afps_pkg::VREF_W-1:0]           vref,
	output logic signed [afps_pkg::VALUE_W-1:0]   value,
	output logic                                  rdy_out
);

	localparam int CW = afps_pkg::CODE_W;
	localparam int VW = afps_pkg::VALUE_W;
	localparam int PW = afps_pkg::PROD_W;
	localparam int SH = afps_pkg::FS_SHIFT;
	localparam int HW = PW - SH;

	logic                 upd;
	logic [VW-1:0]        ext;
	logic [CW-1:0]        mag;

	logic [VW-1:0]        keep_s1, keep_s2, keep_s3;
	logic                 scale_s1, scale_s2, scale_s3;
	logic                 neg_s1, neg_s2, neg_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;
	logic [CW-1:0]        mag_s1;
	logic [afps_pkg::VREF_W-1:0] fsr_s1;
	logic [PW-1:0]        prod_s2;
	logic [HW-1:0]        hi_s3;
	logic [HW:0]          sum_s3;

	logic [HW-SH:0]       fold_hi;
	logic [CW-1:0]        fold_sum;
	logic                 fold_carry;
	logic [VW-1:0]        quot_pos;

	assign upd = (prior != '0) && rdy;
	assign ext = {{(VW-CW){code[CW-1]}}, code};
	assign mag = code[CW-1] ? CW'(-code) : code;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			keep_s1  <= (upd && !nano) ? ext : prior;
			scale_s1 <= upd && nano;
			neg_s1   <= code[CW-1];
			mag_s1   <= mag;
			fsr_s1   <= vref >> gain;
			rdy_s1   <= rdy;
		end
		if (adv.s2) begin
			prod_s2  <= PW'(mag_s1) * PW'(fsr_s1);
			keep_s2  <= keep_s1;
			scale_s2 <= scale_s1;
			neg_s2   <= neg_s1;
			rdy_s2   <= rdy_s1;
		end
		// split P = hi*2^23 + lo; P mod (2^23-1) follows hi + lo
		if (adv.s3) begin
			hi_s3    <= prod_s2[PW-1:SH];
			sum_s3   <= (HW+1)'(prod_s2[PW-1:SH]) + (HW+1)'(prod_s2[SH-1:0]);
			keep_s3  <= keep_s2;
			scale_s3 <= scale_s2;
			neg_s3   <= neg_s2;
			rdy_s3   <= rdy_s2;
		end
	end

	// second fold leaves a value below twice the divisor: one compare fixes it
	assign fold_hi    = sum_s3[HW:SH];
	assign fold_sum   = CW'(fold_hi) + CW'(sum_s3[SH-1:0]);
	assign fold_carry = fold_sum >= afps_pkg::POS_FULL_SCALE;
	assign quot_pos   = VW'(hi_s3) + VW'(fold_hi) + VW'(fold_carry);

	always_comb begin
		if (!scale_s3)
			value = keep_s3;
		else if (neg_s3)
			value = VW'(-hi_s3);
		else
			value = quot_pos;
	end

	assign rdy_out = rdy_s3;

endmodule

[hdl/afps_merge.sv]
// Output stage: gathers lane results and ready bits into the result register.
module afps_merge (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               load,
	input  logic [afps_pkg::CHANNELS-1:0][afps_pkg::VALUE_W-1:0] lane_value,
	input  logic [afps_pkg::CHANNELS-1:0]                      lane_rdy,
	input  logic                                               take,
	output logic                                               room,
	output logic                                               result_valid,
	output afps_pkg::result_t                                  result
);

	logic              valid_q;
	afps_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.value_first  <= lane_value[0];
			result_q.value_second <= lane_value[1];
			result_q.ready_mask   <= lane_rdy[1:0];
		end
	end

	assign room         = !valid_q || take;
	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

[hdl/adc_frame_parse_and_scale.sv]
// Top level: config registers, stage valid chain and the channel lanes.
//
//  channel   signals                                   direction
//  frame     frame_valid, frame_ready, frame           in
//  result    result_valid, result_ready, result        out
//  config    cfg_we, cfg_index, cfg_data               in, write only
//
// One frame per cycle sustained while result_ready holds; each result passes
// lane stages s1, s2 (multiply), s3 (two-step divide) and the result register.
// Each stage fills whenever it is empty, so bubbles close up under output stall.
// Reset clears all stage valids and loads the register reset values.
module adc_frame_parse_and_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 frame_valid,
	output logic                                 frame_ready,
	input  afps_pkg::frame_t                     frame,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output afps_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [afps_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [afps_pkg::VREF_W-1:0]          cfg_data
);

	localparam int N = afps_pkg::CHANNELS;

	logic [afps_pkg::VREF_W-1:0]           vref_q;
	logic [N-1:0][afps_pkg::GAIN_W-1:0]    gain_q;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3, room;
	logic load_out;
	afps_pkg::adv_t adv;

	logic [N-1:0][afps_pkg::CODE_W-1:0]    code;
	logic [N-1:0][afps_pkg::VALUE_W-1:0]   prior;
	logic [N-1:0][afps_pkg::VALUE_W-1:0]   lane_value;
	logic [N-1:0]                          lane_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q <= afps_pkg::VREF_RESET;
			gain_q <= {N{afps_pkg::GAIN_RESET}};
		end else if (cfg_we) begin
			case (cfg_index)
				afps_pkg::REG_VREF:        vref_q    <= cfg_data;
				afps_pkg::REG_GAIN_FIRST:  gain_q[0] <= cfg_data[afps_pkg::GAIN_W-1:0];
				afps_pkg::REG_GAIN_SECOND: gain_q[1] <= cfg_data[afps_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign rdy3     = !v_s3 || room;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign load_out = v_s3 && room;
	assign adv.s3   = v_s2 && rdy3;
	assign adv.s2   = v_s1 && rdy2;
	assign adv.s1   = frame_valid && rdy1;
	assign frame_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= adv.s1 || (v_s1 && !adv.s2);
			v_s2 <= adv.s2 || (v_s2 && !adv.s3);
			v_s3 <= adv.s3 || (v_s3 && !load_out);
		end
	end

	assign code[0]  = frame.code_first;
	assign code[1]  = frame.code_second;
	assign prior[0] = frame.prior_first;
	assign prior[1] = frame.prior_second;

	for (genvar i = 0; i < N; i++) begin : g_lane
		afps_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.code    (code[i]),
			.prior   (prior[i]),
			.rdy     (frame.status_word[i]),
			.nano    (frame.want_nanovolts),
			.gain    (gain_q[i]),
			.vref    (vref_q),
			.value   (lane_value[i]),
			.rdy_out (lane_rdy[i])
		);
	end

	afps_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load_out),
		.lane_value   (lane_value),
		.lane_rdy     (lane_rdy),
		.take         (result_ready),
		.room         (room),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
